/* rtl/pbx_pkg.sv */
// Shared types and constants for the protobuf data field extractor.
package pbx_pkg;

	// Defaults for top-level parameters and register reset values
	localparam int unsigned MAX_MESSAGE_BYTES_DEF = 256;
	localparam logic [15:0] MAX_PORT_RESET = 16'd1024;

	// Byte-level constants of the wire format
	localparam logic [7:0] CONT_BIT_MASK = 8'h80;
	localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
	localparam logic [2:0] MAX_FIRST_WIRE = 3'd5;
	localparam logic [15:0] LEN_SAT = 16'hFFFF;
	localparam logic [15:0] FIXED64_BYTES = 16'd8;
	localparam logic [6:0] SHIFT_SAT = 7'd70;
	localparam logic [6:0] SHIFT_STEP = 7'd7;

	// Wire type codes
	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	// Field numbers of interest
	localparam logic [31:0] FNUM_PORT = 32'd1;
	localparam logic [31:0] FNUM_PAYLOAD = 32'd2;
	localparam logic [31:0] FNUM_WANT = 32'd3;
	localparam logic [31:0] FNUM_REQUEST = 32'd6;

	// Parser phase
	typedef enum logic [2:0] {
		PH_TAG    = 3'd0,
		PH_VALUE  = 3'd1,
		PH_LENGTH = 3'd2,
		PH_SKIP   = 3'd3,
		PH_FIXED  = 3'd4,
		PH_STOP   = 3'd5
	} phase_t;

	// Decoded field number of the entry being parsed
	typedef enum logic [2:0] {
		FLD_OTHER   = 3'd0,
		FLD_PORT    = 3'd1,
		FLD_PAYLOAD = 3'd2,
		FLD_WANT    = 3'd3,
		FLD_REQUEST = 3'd4
	} field_sel_t;

	// One input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	// One result item
	typedef struct packed {
		logic [31:0] port_number;
		logic        has_payload;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
		logic [31:0] call_id;
		logic        reply_wanted;
		logic        looks_like_data;
	} result_t;

	// Handshake control from the top to the stages
	typedef struct packed {
		logic adv;   // stage-1 item is consumed this cycle
		logic emit;  // consumed item closes a message
	} step_ctl_t;

endpackage

/* rtl/pbx_in_if.sv */
// Input byte channel.
interface pbx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, data_byte, last_byte, input ready);
	modport sink(input valid, data_byte, last_byte, output ready);
endinterface

/* rtl/pbx_out_if.sv */
// Result channel.
interface pbx_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] port_number;
	logic        has_payload;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;
	logic [31:0] call_id;
	logic        reply_wanted;
	logic        looks_like_data;

	modport source(output valid, port_number, has_payload, payload_offset, payload_length,
		call_id, reply_wanted, looks_like_data, input ready);
	modport sink(input valid, port_number, has_payload, payload_offset, payload_length,
		call_id, reply_wanted, looks_like_data, output ready);
endinterface

/* rtl/pbx_cfg_if.sv */
// Configuration write channel for the max_port register.
interface pbx_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_port;

	modport source(output valid, max_port, input ready);
	modport sink(input valid, max_port, output ready);
endinterface

/* rtl/pbx_in_stage.sv */
// Input register stage for message bytes.
module pbx_in_stage
	import pbx_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	pbx_in_if.sink       msg,
	input  step_ctl_t    ctl,
	output logic         valid_s1,
	output byte_item_t   item_s1
);

	// Take a new item when the stage is empty or drains this cycle
	assign msg.ready = !valid_s1 || ctl.adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg.ready && msg.valid) begin
			item_s1.data_byte <= msg.data_byte;
			item_s1.last_byte <= msg.last_byte;
		end
	end

endmodule

/* rtl/pbx_parser.sv */
// Wire format parser: per-byte phase update, held fields and result build.
module pbx_parser
	import pbx_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pbx_cfg_if.sink    cfg,
	input  step_ctl_t  ctl,
	input  byte_item_t item_s1,
	output result_t    result,
	output logic [15:0] max_port
);

	phase_t      phase_q, phase_n;
	field_sel_t  fld_q, fld_n;
	logic [63:0] acc_q, acc_n;
	logic [6:0]  shift_q, shift_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] skip_q, skip_n;
	logic [1:0]  fidx_q, fidx_n;
	logic [7:0]  first_q, first_n;
	logic [31:0] port_q, port_n;
	logic [31:0] req_q, req_n;
	logic        want_q, want_n;
	logic        pay_q, pay_n;
	logic [15:0] payoff_q, payoff_n;
	logic [15:0] paylen_q, paylen_n;
	logic [15:0] max_port_q;

	logic [7:0]  b;
	logic [63:0] fed;
	logic [6:0]  shift_inc;
	logic        vdone;
	logic [15:0] len_sat;
	logic [15:0] skip_dec;
	logic [63:0] fix_acc;
	logic [31:0] fnum;

	assign b = item_s1.data_byte;

	// Configuration register, always ready
	assign cfg.ready = 1'b1;
	assign max_port = max_port_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_port_q <= MAX_PORT_RESET;
		end else if (cfg.valid) begin
			max_port_q <= cfg.max_port;
		end
	end

	// Varint, length and fixed32 datapath helpers
	always_comb begin
		fed = acc_q;
		if (!shift_q[6]) begin
			fed = acc_q | (64'(b[6:0]) << shift_q[5:0]);
		end
		shift_inc = (shift_q + SHIFT_STEP > SHIFT_SAT) ? SHIFT_SAT : shift_q + SHIFT_STEP;
		vdone = (b & CONT_BIT_MASK) == 8'h00;
		len_sat = (|fed[63:16]) ? LEN_SAT : fed[15:0];
		skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : 16'd0;
		fix_acc = acc_q | (64'(b) << {fidx_q, 3'b000});
		fnum = fed[34:3];
	end

	// Next-state logic
	always_comb begin
		phase_n = phase_q;
		fld_n = fld_q;
		acc_n = acc_q;
		shift_n = shift_q;
		skip_n = skip_q;
		fidx_n = fidx_q;
		port_n = port_q;
		req_n = req_q;
		want_n = want_q;
		pay_n = pay_q;
		payoff_n = payoff_q;
		paylen_n = paylen_q;
		first_n = (pos_q == 16'd0) ? b : first_q;
		pos_n = (pos_q != LEN_SAT) ? pos_q + 16'd1 : LEN_SAT;

		if (32'(pos_q) < 32'(MAX_MESSAGE_BYTES)) begin
			case (phase_q)
				PH_TAG: begin
					acc_n = fed;
					shift_n = shift_inc;
					if (vdone) begin
						acc_n = '0;
						shift_n = '0;
						case (fnum)
							FNUM_PORT:    fld_n = FLD_PORT;
							FNUM_PAYLOAD: fld_n = FLD_PAYLOAD;
							FNUM_WANT:    fld_n = FLD_WANT;
							FNUM_REQUEST: fld_n = FLD_REQUEST;
							default:      fld_n = FLD_OTHER;
						endcase
						case (fed[2:0])
							WT_VARINT: phase_n = PH_VALUE;
							WT_LEN:    phase_n = PH_LENGTH;
							WT_FIXED32: begin
								phase_n = PH_FIXED;
								fidx_n = 2'd0;
							end
							WT_FIXED64: begin
								phase_n = PH_SKIP;
								skip_n = FIXED64_BYTES;
							end
							default:   phase_n = PH_STOP;
						endcase
					end
				end
				PH_VALUE: begin
					acc_n = fed;
					shift_n = shift_inc;
					if (vdone) begin
						case (fld_q)
							FLD_PORT:    port_n = fed[31:0];
							FLD_WANT:    want_n = |fed;
							FLD_REQUEST: req_n = fed[31:0];
							default:     ;
						endcase
						acc_n = '0;
						shift_n = '0;
						phase_n = PH_TAG;
					end
				end
				PH_LENGTH: begin
					acc_n = fed;
					shift_n = shift_inc;
					if (vdone) begin
						if (fld_q == FLD_PAYLOAD) begin
							payoff_n = pos_q + 16'd1;
							paylen_n = len_sat;
							pay_n = 1'b1;
						end
						skip_n = len_sat;
						acc_n = '0;
						shift_n = '0;
						phase_n = (len_sat != 16'd0) ? PH_SKIP : PH_TAG;
					end
				end
				PH_SKIP: begin
					skip_n = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_n = PH_TAG;
					end
				end
				PH_FIXED: begin
					acc_n = fix_acc;
					if (fidx_q == 2'd3) begin
						if (fld_q == FLD_REQUEST) begin
							req_n = fix_acc[31:0];
						end
						acc_n = '0;
						fidx_n = 2'd0;
						phase_n = PH_TAG;
					end else begin
						fidx_n = fidx_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// Result built from the state after this byte
	always_comb begin
		result.port_number = port_n;
		result.has_payload = pay_n;
		result.payload_offset = pay_n ? payoff_n : 16'd0;
		result.payload_length = pay_n ? paylen_n : 16'd0;
		result.call_id = req_n;
		result.reply_wanted = want_n;
		result.looks_like_data = (pos_n >= 16'd2) && (first_n != 8'h00)
			&& (first_n != BYTE_ALL_ONES) && (first_n[2:0] <= MAX_FIRST_WIRE)
			&& (port_n != 32'd0) && (port_n <= {16'd0, max_port_q});
	end

	// Control state: cleared at reset and after each message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			fld_q <= FLD_OTHER;
			shift_q <= '0;
			pos_q <= '0;
			skip_q <= '0;
			fidx_q <= '0;
			pay_q <= 1'b0;
		end else if (ctl.adv) begin
			if (ctl.emit) begin
				phase_q <= PH_TAG;
				fld_q <= FLD_OTHER;
				shift_q <= '0;
				pos_q <= '0;
				skip_q <= '0;
				fidx_q <= '0;
				pay_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				fld_q <= fld_n;
				shift_q <= shift_n;
				pos_q <= pos_n;
				skip_q <= skip_n;
				fidx_q <= fidx_n;
				pay_q <= pay_n;
			end
		end
	end

	// Held values: cleared at reset and after each message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			first_q <= '0;
			port_q <= '0;
			req_q <= '0;
			want_q <= 1'b0;
			payoff_q <= '0;
			paylen_q <= '0;
		end else if (ctl.adv) begin
			if (ctl.emit) begin
				acc_q <= '0;
				first_q <= '0;
				port_q <= '0;
				req_q <= '0;
				want_q <= 1'b0;
				payoff_q <= '0;
				paylen_q <= '0;
			end else begin
				acc_q <= acc_n;
				first_q <= first_n;
				port_q <= port_n;
				req_q <= req_n;
				want_q <= want_n;
				payoff_q <= payoff_n;
				paylen_q <= paylen_n;
			end
		end
	end

endmodule

/* rtl/pbx_out_stage.sv */
// Result register driving the output channel.
module pbx_out_stage
	import pbx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pbx_out_if.source res,
	input  step_ctl_t ctl,
	input  result_t   result,
	output logic      out_free
);

	logic    valid_q;
	result_t data_q;

	// Register can load when empty or being drained
	assign out_free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.adv && ctl.emit) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.emit) begin
			data_q <= result;
		end
	end

	assign res.valid = valid_q;
	assign res.port_number = data_q.port_number;
	assign res.has_payload = data_q.has_payload;
	assign res.payload_offset = data_q.payload_offset;
	assign res.payload_length = data_q.payload_length;
	assign res.call_id = data_q.call_id;
	assign res.reply_wanted = data_q.reply_wanted;
	assign res.looks_like_data = data_q.looks_like_data;

endmodule

/* rtl/protobuf_data_field_extractor_core.sv */
// Top level of the streaming protobuf data field extractor.
//
// Channels: msg carries one message byte per item with last_byte on the
// final byte; res carries one result item per message; cfg writes max_port
// (reset value 1024) and is always ready.
// Path: the last byte of a message is registered in the input register, and
// its result then loads into the result register that drives res.valid.
// Rate: one byte per cycle unless a last byte waits on the result register;
// the parser updates its phase per byte between the input and result registers.
// Only bytes below MAX_MESSAGE_BYTES of a message are parsed; the rest are
// counted toward the message length only.
// Reset clears the parser, the held fields and the valid flags of both
// registers, and sets max_port to 1024; no clearing pass is needed.
// When res stalls, a finished result waits in the result register while
// bytes keep flowing; a second last byte waits in the input register until
// the result register frees, and msg.ready stays low while it waits.
module protobuf_data_field_extractor_core
	import pbx_pkg::*;
#(
	parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pbx_in_if.sink    msg,
	pbx_out_if.source res,
	pbx_cfg_if.sink   cfg
);

	logic       valid_s1;
	byte_item_t item_s1;
	step_ctl_t  ctl;
	result_t    result;
	logic       out_free;
	logic [15:0] max_port;

	// Stage-1 item moves on unless it closes a message and the result is blocked
	assign ctl.adv = valid_s1 && (!item_s1.last_byte || out_free);
	assign ctl.emit = item_s1.last_byte;

	pbx_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.msg      (msg),
		.ctl      (ctl),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pbx_parser #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.ctl      (ctl),
		.item_s1  (item_s1),
		.result   (result),
		.max_port (max_port)
	);

	pbx_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.ctl      (ctl),
		.result   (result),
		.out_free (out_free)
	);

	// A new result only follows a consumed last byte
	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(ctl.adv && ctl.emit))
		else $error("result appeared without a closing byte");

	// A blocked last byte holds in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ctl.adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled input item lost");

	// Payload fields are zero without a payload entry
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.has_payload |->
			res.payload_offset == 16'd0 && res.payload_length == 16'd0)
		else $error("payload fields set without payload");

	// Plausible data never carries port zero
	a_port_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.looks_like_data |-> res.port_number != 32'd0)
		else $error("plausible flag with port zero");

	// Config register holds between writes
	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg.valid) |-> $stable(max_port))
		else $error("max_port changed without a write");

endmodule

/* sim/pbx_result_checker.sv */
// Result checker for the protobuf data field extractor: predicts each message result and compares.
module pbx_result_checker
	import pbx_pkg::*;
#(
	parameter int unsigned PARSE_LIMIT = MAX_MESSAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pbx_in_if           msg,
	pbx_out_if          res,
	pbx_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned outstanding,
	output int unsigned results_seen,
	output int unsigned plausible_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Decoder state of the message in progress
	logic [15:0] port_limit;
	phase_t      phase;
	logic [63:0] acc;
	logic [6:0]  acc_shift;
	logic [31:0] fnum;
	logic [2:0]  wkind;
	logic [15:0] msg_pos;
	logic [15:0] skip_left;
	logic [1:0]  fix_idx;
	logic [7:0]  lead_byte;
	logic [31:0] port_val;
	logic [31:0] req_val;
	logic        want_val;
	logic        pay_seen;
	logic [15:0] pay_off;
	logic [15:0] pay_len;

	// Results predicted but not yet seen on the result channel
	result_t     predicted[$];
	int unsigned fail_total;
	int unsigned checked_total;
	int unsigned plausible_total;

	function automatic void restart_message();
		phase = PH_TAG;
		acc = '0;
		acc_shift = '0;
		fnum = '0;
		wkind = '0;
		msg_pos = '0;
		skip_left = '0;
		fix_idx = '0;
		lead_byte = '0;
		port_val = '0;
		req_val = '0;
		want_val = 1'b0;
		pay_seen = 1'b0;
		pay_off = '0;
		pay_len = '0;
	endfunction

	// Adds one byte to the varint; high when it was the closing byte
	function automatic logic varint_done(input logic [7:0] b);
		if (acc_shift < 7'd64)
			acc |= 64'(b[6:0]) << acc_shift;
		acc_shift = (acc_shift > 7'd63) ? SHIFT_SAT : acc_shift + SHIFT_STEP;
		return !b[7];
	endfunction

	// One byte inside the parsed window
	task automatic parse_step(input logic [7:0] b, input logic [15:0] pos);
		logic [63:0] v;
		case (phase)
			PH_TAG: begin
				if (varint_done(b)) begin
					fnum = acc[34:3];
					wkind = acc[2:0];
					acc = '0;
					acc_shift = '0;
					case (wkind)
						WT_VARINT: phase = PH_VALUE;
						WT_LEN: phase = PH_LENGTH;
						WT_FIXED32: begin
							phase = PH_FIXED;
							fix_idx = '0;
						end
						WT_FIXED64: begin
							phase = PH_SKIP;
							skip_left = FIXED64_BYTES;
						end
						default: phase = PH_STOP;
					endcase
				end
			end
			PH_VALUE: begin
				if (varint_done(b)) begin
					if (fnum == FNUM_PORT) port_val = acc[31:0];
					else if (fnum == FNUM_WANT) want_val = (acc != 64'd0);
					else if (fnum == FNUM_REQUEST) req_val = acc[31:0];
					acc = '0;
					acc_shift = '0;
					phase = PH_TAG;
				end
			end
			PH_LENGTH: begin
				if (varint_done(b)) begin
					// declared lengths saturate at the 16-bit limit
					v = (acc > 64'(LEN_SAT)) ? 64'(LEN_SAT) : acc;
					if (fnum == FNUM_PAYLOAD) begin
						pay_off = pos + 16'd1;
						pay_len = v[15:0];
						pay_seen = 1'b1;
					end
					skip_left = v[15:0];
					acc = '0;
					acc_shift = '0;
					phase = (skip_left != 16'd0) ? PH_SKIP : PH_TAG;
				end
			end
			PH_SKIP: begin
				if (skip_left != 16'd0) skip_left--;
				if (skip_left == 16'd0) phase = PH_TAG;
			end
			PH_FIXED: begin
				acc |= 64'(b) << (8 * fix_idx);
				if (fix_idx == 2'd3) begin
					if (fnum == FNUM_REQUEST) req_val = acc[31:0];
					acc = '0;
					fix_idx = '0;
					phase = PH_TAG;
				end else begin
					fix_idx = fix_idx + 2'd1;
				end
			end
			default: ;
		endcase
	endtask

	// One accepted byte; the closing byte queues the message result
	task automatic take_byte(input logic [7:0] b, input logic last);
		logic [15:0] pos;
		result_t     r;
		pos = msg_pos;
		if (pos == 16'd0) lead_byte = b;
		if (pos < PARSE_LIMIT) parse_step(b, pos);
		if (pos != LEN_SAT) msg_pos = pos + 16'd1;
		if (last) begin
			r.port_number = port_val;
			r.has_payload = pay_seen;
			r.payload_offset = pay_seen ? pay_off : 16'd0;
			r.payload_length = pay_seen ? pay_len : 16'd0;
			r.call_id = req_val;
			r.reply_wanted = want_val;
			r.looks_like_data = msg_pos >= 16'd2 && lead_byte != 8'h00
				&& lead_byte != BYTE_ALL_ONES && lead_byte[2:0] <= MAX_FIRST_WIRE
				&& port_val >= 32'd1 && port_val <= {16'd0, port_limit};
			predicted.push_back(r);
			restart_message();
		end
	endtask

	function automatic int unsigned field_diff(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	// Watch all three channels at each clock edge
	always @(posedge clk or negedge arst_n) begin
		result_t head;
		if (!arst_n) begin
			restart_message();
			port_limit = MAX_PORT_RESET;
			predicted.delete();
			fail_total = 0;
			checked_total = 0;
			plausible_total = 0;
			mismatches <= 0;
			outstanding <= 0;
			results_seen <= 0;
			plausible_seen <= 0;
		end else begin
			if (cfg.valid && cfg.ready) port_limit = cfg.max_port;
			if (msg.valid && msg.ready) take_byte(msg.data_byte, msg.last_byte);
			if (res.valid && res.ready) begin
				if (predicted.size() == 0) begin
					$error("unexpected result item: port_number 0x%0h", res.port_number);
					fail_total++;
				end else begin
					head = predicted.pop_front();
					fail_total += field_diff("port_number", head.port_number, res.port_number);
					fail_total += field_diff("has_payload", head.has_payload, res.has_payload);
					fail_total += field_diff("payload_offset", head.payload_offset,
						res.payload_offset);
					fail_total += field_diff("payload_length", head.payload_length,
						res.payload_length);
					fail_total += field_diff("call_id", head.call_id, res.call_id);
					fail_total += field_diff("reply_wanted", head.reply_wanted,
						res.reply_wanted);
					fail_total += field_diff("looks_like_data", head.looks_like_data,
						res.looks_like_data);
					checked_total++;
					if (head.looks_like_data) plausible_total++;
				end
			end
			mismatches <= fail_total;
			outstanding <= predicted.size();
			results_seen <= checked_total;
			plausible_seen <= plausible_total;
		end
	end

endmodule

/* sim/protobuf_data_field_extractor_core_tb.sv */
// Testbench top for the protobuf data field extractor: clock, reset, stimulus and verdict.
module protobuf_data_field_extractor_core_tb
	import pbx_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PARSE_LIMIT = 256;
	localparam int          CLK_PERIOD = 10;
	localparam longint      TIMEOUT_NS = 10_000_000;
	localparam int          BASE_GAP_PCT = 37;
	localparam int          HOLD_CYCLES = 120;
	localparam int          PHASE_BYTES = 110;

	// Wire types that stop the parser
	localparam logic [2:0] WT_START_GROUP = 3'd3;
	localparam logic [2:0] WT_END_GROUP = 3'd4;
	localparam logic [2:0] WT_RESERVED6 = 3'd6;
	localparam logic [2:0] WT_RESERVED7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	int          gap_pct = BASE_GAP_PCT;
	int          stall_requests = 0;
	int          stall_served = 0;
	int          bytes_sent = 0;
	int          settings_used = 1;
	logic [15:0] cur_limit = MAX_PORT_RESET;
	logic [7:0]  msg_bytes[$];

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned results_seen;
	int unsigned plausible_seen;

	pbx_in_if  msg_ch();
	pbx_out_if res_ch();
	pbx_cfg_if cfg_ch();

	protobuf_data_field_extractor_core #(
		.MAX_MESSAGE_BYTES(PARSE_LIMIT)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	pbx_result_checker #(
		.PARSE_LIMIT(PARSE_LIMIT)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg            (msg_ch),
		.res            (res_ch),
		.cfg            (cfg_ch),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.plausible_seen (plausible_seen)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Varint encoder; groups above the minimum give overlong encodings
	task automatic put_varint(input logic [63:0] v, input int groups);
		int         need;
		logic [6:0] grp;
		need = 1;
		for (int k = 1; k < 10; k++)
			if ((v >> (7 * k)) != 64'd0) need = k + 1;
		if (groups < need) groups = need;
		for (int k = 0; k < groups; k++) begin
			grp = 7'(v >> (7 * k));
			// junk above bit 63 that the block has to drop
			if (k >= 9 && groups > 10) grp = (k == 9) ? {6'($urandom), v[63]} : 7'($urandom);
			msg_bytes.push_back({(k != groups - 1) ? 1'b1 : 1'b0, grp});
		end
	endtask

	function automatic int pad_groups();
		return ($urandom_range(99) < 85) ? 0 : $urandom_range(1, 12);
	endfunction

	// Port values around the current limit, plus wide ones
	function automatic logic [63:0] pick_port(input logic [15:0] lim);
		case ($urandom_range(9))
			0: return 64'd0;
			1: return 64'd1;
			2: return {48'd0, lim};
			3: return {48'd0, lim} + 64'd1;
			4: return {$urandom, $urandom};
			5: return {32'd1 + 32'($urandom_range(7)), 32'($urandom_range(lim))};
			default: return 64'($urandom_range(lim));
		endcase
	endfunction

	function automatic logic [63:0] pick_value();
		case ($urandom_range(5))
			0: return 64'd0;
			1: return 64'($urandom_range(127));
			2: return 64'($urandom);
			3: return {$urandom, $urandom};
			4: return '1;
			default: return 64'($urandom_range(1, 300));
		endcase
	endfunction

	// One field: tag plus body, mostly of the usual wire type
	task automatic put_field(input logic [15:0] lim);
		logic [63:0] fnum;
		logic [2:0]  wt;
		int          n;
		case ($urandom_range(9))
			0, 1: fnum = 64'(FNUM_PORT);
			2, 3: fnum = 64'(FNUM_PAYLOAD);
			4: fnum = 64'(FNUM_WANT);
			5, 6: fnum = 64'(FNUM_REQUEST);
			7: fnum = 64'($urandom_range(20));
			8: fnum = {$urandom, $urandom} >> 3;
			// wide field numbers whose low 32 bits are 1 to 6, some of them a known field
			default: fnum = {32'd1, 32'($urandom_range(1, 6))};
		endcase
		if ($urandom_range(99) < 70) begin
			if (fnum == 64'(FNUM_PAYLOAD)) wt = WT_LEN;
			else if (fnum == 64'(FNUM_REQUEST) && $urandom_range(1)) wt = WT_FIXED32;
			else wt = WT_VARINT;
		end else begin
			case ($urandom_range(3))
				0: wt = WT_VARINT;
				1: wt = WT_FIXED64;
				2: wt = WT_LEN;
				default: wt = WT_FIXED32;
			endcase
		end
		put_varint({fnum[60:0], wt}, pad_groups());
		case (wt)
			WT_VARINT: put_varint((fnum[31:0] == FNUM_PORT) ? pick_port(lim) : pick_value(),
				pad_groups());
			WT_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom));
			WT_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom));
			default: begin
				n = $urandom_range(6);
				// now and then a declared length far beyond the message
				if ($urandom_range(9) == 0)
					put_varint($urandom_range(1) ? 64'($urandom_range(7, 200000))
						: {$urandom, $urandom}, pad_groups());
				else
					put_varint(64'(n), pad_groups());
				repeat (n) msg_bytes.push_back(8'($urandom));
			end
		endcase
	endtask

	// Send the bytes in msg_bytes as one message, with random gaps
	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++) begin
			while ($urandom_range(99) < gap_pct) begin
				msg_ch.valid <= 1'b0;
				@(posedge clk);
			end
			msg_ch.valid <= 1'b1;
			msg_ch.data_byte <= msg_bytes[i];
			msg_ch.last_byte <= (i == msg_bytes.size() - 1);
			do @(posedge clk); while (!msg_ch.ready);
		end
		bytes_sent += msg_bytes.size();
	endtask

	// Hold the input until every predicted result has come back
	task automatic wait_idle();
		msg_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [15:0] lim);
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_port <= lim;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_limit = lim;
		settings_used++;
	endtask

	// Random messages: mostly well formed, some noise, stopped or truncated
	task automatic run_random(input int n_bytes);
		int         goal;
		int         roll;
		int         n;
		int         cut;
		logic [2:0] stop_wt;
		goal = bytes_sent + n_bytes;
		while (bytes_sent < goal) begin
			msg_bytes.delete();
			roll = $urandom_range(99);
			if (roll < 10) begin
				repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
			end else if (roll < 13) begin
				// long payload body that can carry the message past the parsed window
				put_varint({61'(FNUM_PORT), WT_VARINT}, 0);
				put_varint(pick_port(cur_limit), 0);
				n = $urandom_range(240, 400);
				put_varint({61'(FNUM_PAYLOAD), WT_LEN}, 0);
				put_varint(64'(n), 0);
				repeat (n) msg_bytes.push_back(8'($urandom));
				repeat (2) put_field(cur_limit);
			end else begin
				if ($urandom_range(99) < 60) begin
					put_varint({61'(FNUM_PORT), WT_VARINT}, pad_groups());
					put_varint(pick_port(cur_limit), pad_groups());
				end
				repeat ($urandom_range(1, 5)) put_field(cur_limit);
				if (roll < 25) begin
					case ($urandom_range(3))
						0: stop_wt = WT_START_GROUP;
						1: stop_wt = WT_END_GROUP;
						2: stop_wt = WT_RESERVED6;
						default: stop_wt = WT_RESERVED7;
					endcase
					put_varint({61'($urandom_range(12)), stop_wt}, pad_groups());
					repeat ($urandom_range(4)) msg_bytes.push_back(8'($urandom));
				end
				if ($urandom_range(99) < 15) begin
					cut = $urandom_range(1, msg_bytes.size());
					while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
				end
			end
			send_message();
		end
	endtask

	// Result side: random stalls plus long hold-offs on request
	initial begin
		int hold;
		hold = 0;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_served != stall_requests) begin
				stall_served = stall_requests;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= gap_pct);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		msg_ch.valid <= 1'b0;
		msg_ch.data_byte <= 8'h00;
		msg_ch.last_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.max_port <= 16'd0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed messages under the reset limit
		msg_bytes = '{8'h00};
		send_message();
		msg_bytes = '{8'hFF};
		send_message();
		msg_bytes = '{8'h08, 8'h01};
		send_message();
		msg_bytes = '{8'h08, 8'h80, 8'h08};
		send_message();
		msg_bytes = '{8'h08, 8'h81, 8'h08};
		send_message();
		msg_bytes = '{8'h0F, 8'h01};
		send_message();
		msg_bytes = '{8'h12, 8'h00, 8'h1A, 8'h00, 8'h35, 8'h78, 8'h56, 8'h34, 8'h12,
			8'h18, 8'h01};
		send_message();
		msg_bytes = '{8'h09};
		send_message();
		msg_bytes = '{8'h0D, 8'h11};
		send_message();
		wait_idle();

		// zero limit: nothing can be plausible
		set_limit(16'd0);
		run_random(PHASE_BYTES);
		wait_idle();

		// widest limit, with a long result stall that backs up the input
		set_limit(16'hFFFF);
		stall_requests++;
		run_random(PHASE_BYTES);
		wait_idle();

		// smallest nonzero limit, no idling on either side
		set_limit(16'd1);
		gap_pct = 0;
		run_random(PHASE_BYTES);
		gap_pct = BASE_GAP_PCT;
		wait_idle();

		// random limit, with a pause mid-phase until the results drain
		set_limit(16'($urandom_range(2, 65534)));
		run_random(PHASE_BYTES / 2);
		wait_idle();
		run_random(PHASE_BYTES - PHASE_BYTES / 2);
		wait_idle();

		set_limit(MAX_PORT_RESET);
		stall_requests++;
		run_random(PHASE_BYTES);
		wait_idle();

		set_limit(16'hFFFF);
		run_random(PHASE_BYTES);
		wait_idle();

		$display("Covered %0d messages, %0d bytes, %0d max_port settings.",
			results_seen, bytes_sent, settings_used);
		$display("%0d messages were judged to look like data.", plausible_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results still expected", outstanding);
		$display("Mismatches found");
		$finish;
	end

endmodule
